### hdl/fct_pkg.sv
// ---------------------------------------------------------------------------
// fct_pkg
// Types and constants shared by the flow counter table blocks.
// ---------------------------------------------------------------------------
`default_nettype none

package fct_pkg;

  // Flow table geometry
  localparam int unsigned FLOW_SLOTS = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned KEY_W      = 96;
  localparam int unsigned PKT_W      = 32;
  localparam int unsigned BYTES_W    = 48;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned TYPE_W     = 16;

  // Header layout (byte offsets from the start of the frame)
  localparam int unsigned TYPE_HI_OFF  = 12;
  localparam int unsigned TYPE_LO_OFF  = 13;
  localparam int unsigned IHL_OFF      = 14;
  localparam int unsigned IP_ADDR_OFF  = 26;
  localparam int unsigned IP_ADDR_LEN  = 8;
  localparam int unsigned PORT_LEN     = 4;
  localparam int unsigned ETH_HDR_LEN  = 14;
  localparam int unsigned IP_MIN_HDR   = 20;
  localparam int unsigned TP_HDR_LEN   = 20;

  localparam logic [TYPE_W-1:0] ETHERTYPE_RST = 16'h0800;

  typedef enum logic [1:0] {
    ST_COUNTED    = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_SHORT      = 2'd2,
    ST_BAD_TYPE   = 2'd3
  } status_t;

  // Decided frame handed from the parser to the table
  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } frame_rec_t;

  typedef struct packed {
    logic               drop;
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [PKT_W-1:0]   packets;
    logic [BYTES_W-1:0] bytes;
  } result_t;

endpackage

`default_nettype wire

### hdl/fct_parser.sv
// ---------------------------------------------------------------------------
// fct_parser
// Tracks the byte offset, captures the header fields as they stream by and
// classifies the frame at its last byte.
// ---------------------------------------------------------------------------
`default_nettype none

module fct_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 16383
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic                      byte_valid,
  input  wire logic [7:0]                frame_byte,
  input  wire logic                      last_byte,
  input  wire logic [fct_pkg::TYPE_W-1:0] ethertype,
  output fct_pkg::frame_rec_t            rec_r
);
  import fct_pkg::*;

  localparam int unsigned OFF_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [OFF_W-1:0] off_r;
  logic [7:0]       type_hi_r;
  logic [7:0]       type_lo_r;
  logic [3:0]       ihl_r;
  logic [7:0]       addr_r [IP_ADDR_LEN];
  logic [7:0]       port_r [PORT_LEN];

  logic              byte_acc;
  logic [3:0]        ihl_cur;
  logic [OFF_W-1:0]  tp;
  logic [OFF_W-1:0]  tp_d;
  logic              port_hit;
  logic [TYPE_W-1:0] type_n;
  logic [7:0]        addr_n [IP_ADDR_LEN];
  logic [7:0]        port_n [PORT_LEN];
  logic [OFF_W-1:0]  len_w;
  logic [OFF_W-1:0]  len_need;
  logic [KEY_W-1:0]  key_n;
  status_t           status_n;

  assign byte_acc = adv && byte_valid;

  // IHL becomes known at byte 14; ports of a zero IHL start at that very byte
  always_comb begin
    ihl_cur  = (off_r == OFF_W'(IHL_OFF)) ? frame_byte[3:0] : ihl_r;
    tp       = OFF_W'(ETH_HDR_LEN) + OFF_W'({ihl_cur, 2'b00});
    tp_d     = off_r - tp;
    port_hit = (off_r >= tp) && (tp_d < OFF_W'(PORT_LEN));
  end

  // Field values including the current byte
  always_comb begin
    type_n[15:8] = (off_r == OFF_W'(TYPE_HI_OFF)) ? frame_byte : type_hi_r;
    type_n[7:0]  = (off_r == OFF_W'(TYPE_LO_OFF)) ? frame_byte : type_lo_r;
    for (int i = 0; i < IP_ADDR_LEN; i++) begin
      addr_n[i] = (off_r == OFF_W'(IP_ADDR_OFF + i)) ? frame_byte : addr_r[i];
    end
    for (int j = 0; j < PORT_LEN; j++) begin
      port_n[j] = (port_hit && (tp_d[1:0] == 2'(j))) ? frame_byte : port_r[j];
    end
    // key in wire order, first byte in the top bits
    for (int i = 0; i < IP_ADDR_LEN; i++) begin
      key_n[KEY_W-1-8*i -: 8] = addr_n[i];
    end
    for (int j = 0; j < PORT_LEN; j++) begin
      key_n[KEY_W-1-8*(IP_ADDR_LEN+j) -: 8] = port_n[j];
    end
  end

  always_comb begin
    len_w    = (off_r == OFF_W'(MAX_FRAME_BYTES)) ? off_r : off_r + OFF_W'(1);
    len_need = OFF_W'(ETH_HDR_LEN + TP_HDR_LEN) + OFF_W'({ihl_cur, 2'b00});
    if (len_w < OFF_W'(ETH_HDR_LEN)) begin
      status_n = ST_SHORT;
    end else if (type_n != ethertype) begin
      status_n = ST_BAD_TYPE;
    end else if (len_w < OFF_W'(ETH_HDR_LEN + IP_MIN_HDR)) begin
      status_n = ST_SHORT;
    end else if (len_w < len_need) begin
      status_n = ST_SHORT;
    end else begin
      status_n = ST_COUNTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else if (byte_acc) begin
      if (last_byte) begin
        off_r <= '0;
      end else if (off_r < OFF_W'(MAX_FRAME_BYTES)) begin
        off_r <= off_r + OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc) begin
      type_hi_r <= type_n[15:8];
      type_lo_r <= type_n[7:0];
      ihl_r     <= ihl_cur;
      for (int i = 0; i < IP_ADDR_LEN; i++) begin
        addr_r[i] <= addr_n[i];
      end
      for (int j = 0; j < PORT_LEN; j++) begin
        port_r[j] <= port_n[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.valid <= 1'b0;
    end else if (adv) begin
      rec_r.valid <= byte_acc && last_byte;
    end
    if (byte_acc && last_byte) begin
      rec_r.status <= status_n;
      rec_r.key    <= key_n;
      rec_r.len    <= LEN_W'(len_w);
    end
  end

endmodule

`default_nettype wire

### hdl/fct_table.sv
// ---------------------------------------------------------------------------
// fct_table
// Fully associative flow table with saturating packet and byte counters,
// and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module fct_table (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  fct_pkg::frame_rec_t      rec,
  input  wire logic                res_ready,
  output logic                     res_valid_r,
  output fct_pkg::result_t         res_r
);
  import fct_pkg::*;

  logic [FLOW_SLOTS-1:0] slot_vld_r;
  logic [KEY_W-1:0]      key_r   [FLOW_SLOTS];
  logic [PKT_W-1:0]      pkt_r   [FLOW_SLOTS];
  logic [BYTES_W-1:0]    bytes_r [FLOW_SLOTS];

  logic                  fire;
  logic [FLOW_SLOTS-1:0] hit;
  logic                  any_hit;
  logic                  any_free;
  logic [SLOT_W-1:0]     hit_idx;
  logic [SLOT_W-1:0]     free_idx;
  logic [SLOT_W-1:0]     slot;
  logic                  counted;
  logic [PKT_W-1:0]      pkt_old;
  logic [BYTES_W-1:0]    bytes_old;
  logic [PKT_W-1:0]      pkt_new;
  logic [BYTES_W:0]      bytes_sum;
  logic [BYTES_W-1:0]    bytes_new;
  result_t               res_nxt;

  assign fire = adv && rec.valid;

  always_comb begin
    for (int i = 0; i < FLOW_SLOTS; i++) begin
      hit[i] = slot_vld_r[i] && (key_r[i] == rec.key);
    end
    any_hit  = |hit;
    any_free = ~&slot_vld_r;
    hit_idx  = '0;
    free_idx = '0;
    // downward scan so the lowest slot wins
    for (int i = FLOW_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (!slot_vld_r[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
    slot    = any_hit ? hit_idx : free_idx;
    counted = (rec.status == ST_COUNTED) && (any_hit || any_free);
  end

  // a newly taken slot starts from zero
  always_comb begin
    pkt_old   = any_hit ? pkt_r[hit_idx]   : '0;
    bytes_old = any_hit ? bytes_r[hit_idx] : '0;
    pkt_new   = (&pkt_old) ? pkt_old : pkt_old + PKT_W'(1);
    bytes_sum = {1'b0, bytes_old} + (BYTES_W + 1)'(rec.len);
    bytes_new = bytes_sum[BYTES_W] ? {BYTES_W{1'b1}} : bytes_sum[BYTES_W-1:0];
  end

  always_comb begin
    res_nxt = '0;
    case (rec.status)
      ST_SHORT: begin
        res_nxt.drop   = 1'b1;
        res_nxt.status = ST_SHORT;
      end
      ST_BAD_TYPE: begin
        res_nxt.drop   = 1'b1;
        res_nxt.status = ST_BAD_TYPE;
      end
      default: begin
        if (counted) begin
          res_nxt.status  = ST_COUNTED;
          res_nxt.slot    = slot;
          res_nxt.packets = pkt_new;
          res_nxt.bytes   = bytes_new;
        end else begin
          res_nxt.status = ST_TABLE_FULL;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
    end else if (fire && counted) begin
      slot_vld_r[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && counted) begin
      key_r[slot]   <= rec.key;
      pkt_r[slot]   <= pkt_new;
      bytes_r[slot] <= bytes_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (fire) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/flow_counter_table_core.sv
// ---------------------------------------------------------------------------
// flow_counter_table_core
// Per-flow packet and byte counter for IPv4 frames on a byte stream.
// ---------------------------------------------------------------------------
// Takes one frame byte per cycle and gives one result per frame, registered
// in the parser's frame record and then in the result register. Headers are
// parsed on the fly, so the flow lookup, counter update and result all happen
// in the same cycle at frame end against a 16-slot fully associative table;
// slots are never freed and the table needs no clearing after reset. Input
// stalls only while a decided frame waits behind a result not yet taken.
`default_nettype none

module flow_counter_table_core #(
  parameter int unsigned MAX_FRAME_BYTES = 16383
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  wire logic        in_tlast,   // last_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // [3:0] flow_slot, [35:4] flow_packets,
                                       // [83:36] flow_bytes, [87:84] zero
  output logic [2:0]       out_tuser,  // [0] drop_frame, [2:1] status
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data // accepted_ethertype
);
  import fct_pkg::*;

  logic [TYPE_W-1:0] ethertype_r;
  logic              adv;
  frame_rec_t        rec;
  logic              res_valid;
  result_t           res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ethertype_r <= ETHERTYPE_RST;
    end else if (cfg_wr_en) begin
      ethertype_r <= cfg_wr_data;
    end
  end

  // whole pipe moves unless a decided frame is blocked by a pending result
  assign adv       = !rec.valid || !res_valid || out_tready;
  assign in_tready = adv;

  fct_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .byte_valid (in_tvalid),
    .frame_byte (in_tdata),
    .last_byte  (in_tlast),
    .ethertype  (ethertype_r),
    .rec_r      (rec)
  );

  fct_table u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .rec         (rec),
    .res_ready   (out_tready),
    .res_valid_r (res_valid),
    .res_r       (res)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {4'b0000, res.bytes, res.packets, res.slot};
  assign out_tuser  = {res.status, res.drop};

endmodule

`default_nettype wire

### bench/flow_counter_checker.sv
// ---------------------------------------------------------------------------
// flow_counter_checker
// Watches the byte stream, the result stream and the type register write
// port of flow_counter_table_core. Keeps its own copy of the header bytes and
// of the flow table, works out the verdict of every frame at its last byte,
// and compares each result transaction field by field with the oldest
// verdict still waiting.
// ---------------------------------------------------------------------------
`default_nettype none

module flow_counter_checker #(
  parameter int MAX_FRAME_BYTES = 16383
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [87:0] out_tdata,
  input  wire logic [2:0]  out_tuser,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  output int               fail_count,
  output int               pending
);
  import fct_pkg::*;

  localparam int HDR_BYTES = 78;
  localparam logic [63:0] BYTES_SAT = 64'hFFFF_FFFF_FFFF;

  logic [7:0]         hdr_bytes [0:HDR_BYTES-1];
  int                 frame_pos;
  logic [TYPE_W-1:0]  accepted_type;
  logic               slot_used [0:FLOW_SLOTS-1];
  logic [KEY_W-1:0]   slot_key  [0:FLOW_SLOTS-1];
  logic [PKT_W-1:0]   pkt_cnt   [0:FLOW_SLOTS-1];
  logic [BYTES_W-1:0] byte_cnt  [0:FLOW_SLOTS-1];
  result_t            frame_verdicts [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string field, input logic [63:0] got,
                        input logic [63:0] want);
    fail_count++;
    // keep the log readable when the block is badly broken
    if (fail_count <= 40)
      $display("checker: %s mismatch at %0t, got %0h want %0h",
               field, $realtime, got, want);
  endtask

  // Takes one frame byte; at the last byte decides the frame and queues
  // the result it must produce.
  task automatic decide_frame_byte(input logic [7:0] b, input logic last);
    int               len;
    int               tp;
    int               hit;
    logic [KEY_W-1:0] key;
    logic [63:0]      sum;
    result_t          r;
    if (frame_pos < HDR_BYTES) hdr_bytes[frame_pos] = b;
    if (!last) begin
      if (frame_pos < MAX_FRAME_BYTES) frame_pos++;
      return;
    end
    len = frame_pos + 1;
    if (len > MAX_FRAME_BYTES) len = MAX_FRAME_BYTES;
    frame_pos = 0;

    r = '0;
    r.drop = 1'b1;
    tp = ETH_HDR_LEN + 4 * int'(hdr_bytes[IHL_OFF][3:0]);
    if (len < ETH_HDR_LEN) begin
      r.status = ST_SHORT;
    end else if ({hdr_bytes[TYPE_HI_OFF], hdr_bytes[TYPE_LO_OFF]} != accepted_type) begin
      r.status = ST_BAD_TYPE;
    end else if (len < ETH_HDR_LEN + IP_MIN_HDR || len < tp + TP_HDR_LEN) begin
      r.status = ST_SHORT;
    end else begin
      r.drop = 1'b0;
      // addresses then ports, wire order, first byte in the top bits
      for (int k = 0; k < IP_ADDR_LEN; k++)
        key[KEY_W-1-8*k -: 8] = hdr_bytes[IP_ADDR_OFF+k];
      for (int k = 0; k < PORT_LEN; k++)
        key[31-8*k -: 8] = hdr_bytes[tp+k];
      hit = -1;
      for (int i = 0; i < FLOW_SLOTS; i++)
        if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
      for (int i = 0; i < FLOW_SLOTS; i++)
        if (hit < 0 && !slot_used[i]) begin
          hit          = i;
          slot_used[i] = 1'b1;
          slot_key[i]  = key;
          pkt_cnt[i]   = '0;
          byte_cnt[i]  = '0;
        end
      if (hit < 0) begin
        r.status = ST_TABLE_FULL;
      end else begin
        r.status = ST_COUNTED;
        if (pkt_cnt[hit] != '1) pkt_cnt[hit] = pkt_cnt[hit] + 1'b1;
        sum = {16'd0, byte_cnt[hit]} + 64'(len);
        byte_cnt[hit] = (sum > BYTES_SAT) ? '1 : sum[BYTES_W-1:0];
        r.slot    = hit[SLOT_W-1:0];
        r.packets = pkt_cnt[hit];
        r.bytes   = byte_cnt[hit];
      end
    end
    frame_verdicts.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      frame_pos     = 0;
      accepted_type = ETHERTYPE_RST;
      for (int i = 0; i < FLOW_SLOTS; i++) slot_used[i] = 1'b0;
      frame_verdicts.delete();
    end else begin
      if (cfg_wr_en) accepted_type = cfg_wr_data;
      if (in_tvalid && in_tready) decide_frame_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (frame_verdicts.size() == 0) begin
          report("unexpected result", {out_tdata[59:0], out_tuser, 1'b0}, 64'd0);
        end else begin
          want = frame_verdicts.pop_front();
          if (out_tuser[0] !== want.drop)
            report("drop_frame", 64'(out_tuser[0]), 64'(want.drop));
          if (out_tuser[2:1] !== want.status)
            report("status", 64'(out_tuser[2:1]), 64'(want.status));
          if (out_tdata[3:0] !== want.slot)
            report("flow_slot", 64'(out_tdata[3:0]), 64'(want.slot));
          if (out_tdata[35:4] !== want.packets)
            report("flow_packets", 64'(out_tdata[35:4]), 64'(want.packets));
          if (out_tdata[83:36] !== want.bytes)
            report("flow_bytes", 64'(out_tdata[83:36]), 64'(want.bytes));
          if (out_tdata[87:84] !== 4'd0)
            report("tdata padding", 64'(out_tdata[87:84]), 64'd0);
        end
      end
    end
    pending = frame_verdicts.size();
  end

endmodule

`default_nettype wire

### bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// Top of the flow counter table bench. Builds Ethernet/IPv4 frames byte by
// byte, starting with hand-picked length and header corner cases, then
// random frames over several type register settings, with random gaps on
// the byte stream and random stalls on the result stream. Checking is done
// by flow_counter_checker; this module gives the verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  import fct_pkg::*;

  localparam int MAX_FRAME = 16383;
  localparam int ITEMS     = 1950;
  localparam int IDLE_LIMIT = 3000;
  localparam int POOL      = 24;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'd0;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [87:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;

  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          beats_sent  = 0;
  logic [15:0] cur_type    = ETHERTYPE_RST;
  logic [95:0] flow_pool [0:POOL-1];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  flow_counter_table_core #(.MAX_FRAME_BYTES(MAX_FRAME)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  flow_counter_checker #(.MAX_FRAME_BYTES(MAX_FRAME)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side back-pressure: ready runs, short stalls, the odd long one
  always @(posedge clk) begin : sink_pace
    int hold;
    int r;
    if (hold > 0) begin
      hold = hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        out_tready <= 1'b1;
        hold = $urandom_range(0, 30);
      end else if (r < 88) begin
        out_tready <= 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        hold = $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic send_beat(input logic [7:0] d, input logic last, input bit no_gaps);
    int g;
    g = no_gaps ? 0 : pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  // Frame with the given type, IHL and flow key; bytes past the header
  // area and all unset header bytes are random.
  task automatic send_frame(input logic [15:0] etype, input logic [3:0] ihl,
                            input logic [95:0] key, input int len, input bit no_gaps);
    logic [7:0] hdr [0:79];
    int         tp;
    for (int i = 0; i < 80; i++) hdr[i] = 8'($urandom);
    tp = ETH_HDR_LEN + 4 * int'(ihl);
    for (int k = 0; k < 4; k++) hdr[tp+k] = key[31-8*k -: 8];
    for (int k = 0; k < 8; k++) hdr[IP_ADDR_OFF+k] = key[95-8*k -: 8];
    hdr[IHL_OFF][3:0] = ihl;
    hdr[TYPE_HI_OFF]  = etype[15:8];
    hdr[TYPE_LO_OFF]  = etype[7:0];
    for (int i = 0; i < len; i++)
      send_beat((i < 80) ? hdr[i] : 8'($urandom), i == len - 1, no_gaps);
  endtask

  // drain to idle, then let the pipeline settle
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_type(input logic [15:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_type     = v;
  endtask

  task automatic send_random_frame();
    int          r;
    int          need;
    int          len;
    logic [3:0]  ihl;
    logic [15:0] etype;
    bit          no_gaps;
    r       = $urandom_range(0, 99);
    no_gaps = ($urandom_range(0, 3) == 0);
    ihl     = ($urandom_range(0, 99) < 75) ? 4'd5 : 4'($urandom_range(0, 15));
    need    = ETH_HDR_LEN + 4 * int'(ihl) + TP_HDR_LEN;
    if (need < ETH_HDR_LEN + IP_MIN_HDR) need = ETH_HDR_LEN + IP_MIN_HDR;
    etype   = cur_type;
    len     = need + $urandom_range(0, 26);
    if (r < 70) begin
      // well-formed, correct type
    end else if (r < 80) begin
      etype = ($urandom_range(0, 1) == 0) ? cur_type ^ (16'h1 << $urandom_range(0, 15))
                                          : 16'($urandom);
    end else if (r < 92) begin
      len = $urandom_range(1, need - 1);
    end else begin
      if ($urandom_range(0, 1) == 0) etype = 16'($urandom);
      len = $urandom_range(1, 100);
    end
    send_frame(etype, ihl, flow_pool[$urandom_range(0, POOL - 1)], len, no_gaps);
  endtask

  initial begin : stimulus
    logic [95:0] k_zero;
    logic [95:0] k_ones;
    logic [95:0] k_mix;
    logic [15:0] phase_type [0:4];
    int          phase;
    int          rand_base;
    int          rand_items;
    k_zero = '0;
    k_ones = '1;
    k_mix  = {$urandom, $urandom, $urandom};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: length thresholds, type check, IHL extremes, long frame
    send_frame(ETHERTYPE_RST, 4'd5, k_zero, 1, 1'b0);
    send_frame(ETHERTYPE_RST, 4'd5, k_zero, 13, 1'b0);
    send_frame(ETHERTYPE_RST, 4'd5, k_zero, 14, 1'b0);
    send_frame(16'h0801, 4'd5, k_zero, 14, 1'b0);
    send_frame(ETHERTYPE_RST, 4'd5, k_zero, 33, 1'b0);
    send_frame(ETHERTYPE_RST, 4'd5, k_zero, 53, 1'b0);
    send_frame(ETHERTYPE_RST, 4'd5, k_zero, 54, 1'b0);
    send_frame(ETHERTYPE_RST, 4'd5, k_zero, 54, 1'b1);
    send_frame(ETHERTYPE_RST, 4'd5, k_ones, 60, 1'b0);
    send_frame(ETHERTYPE_RST, 4'd0, k_mix, 34, 1'b0);   // ports overlap the IP header
    send_frame(ETHERTYPE_RST, 4'd15, k_mix, 93, 1'b0);
    send_frame(ETHERTYPE_RST, 4'd15, k_mix, 94, 1'b0);
    send_frame(16'hF7FF, 4'd5, k_ones, 60, 1'b0);
    send_frame(ETHERTYPE_RST, 4'd5, k_ones, 120, 1'b1);  // runs past the header area
    set_type(16'h86DD);
    send_frame(ETHERTYPE_RST, 4'd5, k_zero, 60, 1'b0);
    send_frame(16'h86DD, 4'd5, k_zero, 60, 1'b0);

    // random: a pool of flows larger than the table so it fills up
    for (int i = 0; i < POOL; i++) flow_pool[i] = {$urandom, $urandom, $urandom};
    phase_type[0] = 16'hFFFF;
    phase_type[1] = 16'h0000;
    phase_type[2] = 16'($urandom);
    phase_type[3] = ETHERTYPE_RST;
    phase_type[4] = 16'h86DD;
    phase       = 0;
    rand_base   = beats_sent;
    rand_items  = ITEMS - rand_base;
    set_type(phase_type[0]);
    while (beats_sent - rand_base < rand_items) begin
      send_random_frame();
      if (phase < 4 && beats_sent - rand_base >= (phase + 1) * rand_items / 5) begin
        phase++;
        set_type(phase_type[phase]);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hdl/fct_pkg.sv
hdl/fct_parser.sv
hdl/fct_table.sv
hdl/flow_counter_table_core.sv
bench/flow_counter_checker.sv
bench/tb.sv
